/* hw/rtl/banked_expansion_memory_port_unit_assert.svh */
// Assertion macros for the banked expansion memory port unit.
// Each check samples on the rising edge of clk.
// BEMP_ASSERT turns off while rst_n is low; BEMP_ASSERT_ALWAYS also holds in reset.
`ifndef BANKED_EXPANSION_MEMORY_PORT_UNIT_ASSERT_SVH
`define BANKED_EXPANSION_MEMORY_PORT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define BEMP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bemp assertion failed");

`define BEMP_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("bemp assertion failed");

`else

`define BEMP_ASSERT(label, prop)

`define BEMP_ASSERT_ALWAYS(label, prop)

`endif

`endif

/* hw/rtl/bemp_pkg.sv */
package bemp_pkg;

    // Command codes carried in func
    localparam logic [2:0] FUNC_ADDR = 3'd0;
    localparam logic [2:0] FUNC_BANK = 3'd1;
    localparam logic [2:0] FUNC_BYTE = 3'd2;
    localparam logic [2:0] FUNC_NEXT = 3'd3;
    localparam logic [2:0] FUNC_WORD = 3'd4;

    // Remainder unit: 16-bit operand, reciprocal scaled by 2^32
    localparam int OPND_W    = 16;
    localparam int RCP_SHIFT = 32;
    localparam int RCP_W     = RCP_SHIFT + 1;
    localparam int PROD_W    = OPND_W + RCP_W;

    // Request from the sequencer to the remainder unit
    typedef struct packed {
        logic start;
        logic sel_bank;
    } bemp_rem_req_t;

endpackage

/* hw/rtl/bemp_cmd_if.sv */
interface bemp_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic       write;
    logic [7:0] acc_in;
    logic [7:0] lo_in;
    logic [7:0] hi_in;

    modport source (output valid, output func, output write, output acc_in,
                    output lo_in, output hi_in, input ready);
    modport sink (input valid, input func, input write, input acc_in,
                  input lo_in, input hi_in, output ready);
endinterface

/* hw/rtl/bemp_rsp_if.sv */
interface bemp_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] acc_out;
    logic [7:0] lo_out;
    logic [7:0] hi_out;

    modport source (output valid, output acc_out, output lo_out, output hi_out,
                    input ready);
    modport sink (input valid, input acc_out, input lo_out, input hi_out,
                  output ready);
endinterface

/* hw/rtl/bemp_rem_unit.sv */
// Remainder by one of two constant divisors through a rounded-up reciprocal.
// One shared multiplier forms the quotient in the first pass and the product
// to subtract in the second. The reciprocal error times any 16-bit operand
// stays below 2^32, so the quotient is exact.
module bemp_rem_unit #(
    parameter int BANK_DIV = 16,
    parameter int ADDR_DIV = 65536
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bemp_pkg::bemp_rem_req_t req,
    input  logic [15:0]           operand,
    output logic                  done,
    output logic [15:0]           result
);
    import bemp_pkg::*;

    localparam logic [63:0]      RCP_NUM    = 64'd1 << RCP_SHIFT;
    localparam logic [RCP_W-1:0] BANK_RCP   =
        RCP_W'((RCP_NUM + 64'(BANK_DIV) - 64'd1) / 64'(BANK_DIV));
    localparam logic [RCP_W-1:0] ADDR_RCP   =
        RCP_W'((RCP_NUM + 64'(ADDR_DIV) - 64'd1) / 64'(ADDR_DIV));
    localparam logic [RCP_W-1:0] BANK_DIV_W = RCP_W'(BANK_DIV);
    localparam logic [RCP_W-1:0] ADDR_DIV_W = RCP_W'(ADDR_DIV);

    logic [OPND_W-1:0] opnd_reg;
    logic [OPND_W-1:0] quot_reg;
    logic [OPND_W-1:0] rem_reg;
    logic              busy_reg;
    logic              phase_reg;
    logic              sel_bank_reg;
    logic              done_reg;

    logic [OPND_W-1:0] mul_a;
    logic [RCP_W-1:0]  mul_b;
    logic [PROD_W-1:0] product;

    // Feed the shared multiplier: operand by reciprocal, then quotient by divisor
    always_comb
    begin
        mul_a = phase_reg ? quot_reg : opnd_reg;
        if (phase_reg)
        begin
            mul_b = sel_bank_reg ? BANK_DIV_W : ADDR_DIV_W;
        end
        else
        begin
            mul_b = sel_bank_reg ? BANK_RCP : ADDR_RCP;
        end
        product = {{RCP_W{1'b0}}, mul_a} * {{OPND_W{1'b0}}, mul_b};
    end

    // Sequence the two passes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opnd_reg     <= '0;
            quot_reg     <= '0;
            rem_reg      <= '0;
            busy_reg     <= 1'b0;
            phase_reg    <= 1'b0;
            sel_bank_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                opnd_reg     <= operand;
                sel_bank_reg <= req.sel_bank;
                phase_reg    <= 1'b0;
                busy_reg     <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (!phase_reg)
                begin
                    quot_reg  <= product[RCP_SHIFT +: OPND_W];
                    phase_reg <= 1'b1;
                end
                else
                begin
                    rem_reg   <= opnd_reg - product[OPND_W-1:0];
                    phase_reg <= 1'b0;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = rem_reg;

endmodule

/* hw/rtl/bemp_store.sv */
// Single-port byte store with registered read data.
module bemp_store #(
    parameter int DEPTH = 1048576,
    parameter int AW    = 20
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);
    logic [7:0] mem_reg [DEPTH];
    logic [7:0] rdata_reg;

    // Write or read one byte per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/banked_expansion_memory_port_unit.sv */
// Channel | Role   | Payload
// cmd     | sink   | func[2:0], write, acc_in[7:0], lo_in[7:0], hi_in[7:0]
// rsp     | source | acc_out[7:0], lo_out[7:0], hi_out[7:0]
//
// One command at a time; cmd.ready is high only while the sequencer is idle.
// States passed before S_OUT: none for gets and unused codes; S_WR_LO for a
// byte write; S_RD_LO, S_RD_TAIL for a byte read; S_WR_LO, S_WR_HI for a word
// write; S_RD_LO, S_RD_HI, S_RD_TAIL for a word read; S_REM for an address or bank set.
// The single-port store takes one byte access per cycle.
// A result waits in the output register while rsp.ready is low; a new command
// is taken meanwhile, and its result waits until the register frees.
// Reset clears pointer, bank and handshake state; store contents are not reset.
`include "banked_expansion_memory_port_unit_assert.svh"

module banked_expansion_memory_port_unit #(
    parameter int BANK_COUNT = 16,
    parameter int BANK_BYTES = 65536
) (
    input  logic       clk,
    input  logic       rst_n,
    bemp_cmd_if.sink   cmd,
    bemp_rsp_if.source rsp
);
    import bemp_pkg::*;

    localparam int DEPTH = BANK_COUNT * BANK_BYTES;
    localparam int AW    = $clog2(BANK_BYTES);
    localparam int BW    = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
    localparam int MAW   = $clog2(DEPTH);
    localparam logic [AW-1:0] ADDR_MAX = AW'(BANK_BYTES - 1);
    localparam logic [BW-1:0] BANK_MAX = BW'(BANK_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REM,
        S_WR_LO,
        S_WR_HI,
        S_RD_LO,
        S_RD_HI,
        S_RD_TAIL,
        S_OUT
    } state_t;

    state_t        state_reg;
    logic [2:0]    func_reg;
    logic [7:0]    acc_reg;
    logic [7:0]    lo_reg;
    logic [7:0]    hi_reg;
    logic [AW-1:0] addr_reg;
    logic [BW-1:0] bank_reg;
    logic          rsp_valid_reg;
    logic [7:0]    rsp_acc_reg;
    logic [7:0]    rsp_lo_reg;
    logic [7:0]    rsp_hi_reg;

    logic          accept;
    bemp_rem_req_t rem_req;
    logic [15:0]   rem_operand;
    logic          rem_done;
    logic [15:0]   rem_result;

    logic [AW-1:0] addr_adv;
    logic [BW-1:0] bank_adv;
    logic [15:0]   addr_wide;
    logic          inc;
    logic          word;
    logic          addr_get;
    logic          bank_get;

    logic          mem_we;
    logic [MAW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign addr_wide = 16'(addr_reg);
    assign inc       = (func_reg != FUNC_BYTE);
    assign word      = (func_reg == FUNC_WORD);
    assign addr_get  = (cmd.func == FUNC_ADDR) && !cmd.write;
    assign bank_get  = (cmd.func == FUNC_BANK) && !cmd.write;

    // Start the remainder unit on address or bank set
    always_comb
    begin
        rem_req.start    = accept && cmd.write &&
                           ((cmd.func == FUNC_ADDR) || (cmd.func == FUNC_BANK));
        rem_req.sel_bank = (cmd.func == FUNC_BANK);
        rem_operand      = (cmd.func == FUNC_BANK) ? {8'h00, cmd.lo_in}
                                                   : {cmd.hi_in, cmd.lo_in};
    end

    bemp_rem_unit #(
        .BANK_DIV (BANK_COUNT),
        .ADDR_DIV (BANK_BYTES)
    ) u_rem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (rem_req),
        .operand (rem_operand),
        .done    (rem_done),
        .result  (rem_result)
    );

    // Post-increment: wrap the address and carry into the bank
    always_comb
    begin
        if (addr_reg == ADDR_MAX)
        begin
            addr_adv = '0;
            bank_adv = (bank_reg == BANK_MAX) ? '0 : bank_reg + 1'b1;
        end
        else
        begin
            addr_adv = addr_reg + 1'b1;
            bank_adv = bank_reg;
        end
    end

    // Store port: cell index from bank and pointer
    always_comb
    begin
        mem_we    = (state_reg == S_WR_LO) || (state_reg == S_WR_HI);
        mem_wdata = (state_reg == S_WR_HI) ? hi_reg : lo_reg;
        mem_addr  = MAW'(bank_reg) * MAW'(BANK_BYTES) + MAW'(addr_reg);
    end

    bemp_store #(
        .DEPTH (DEPTH),
        .AW    (MAW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Sequencer, working registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            func_reg      <= '0;
            acc_reg       <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            addr_reg      <= '0;
            bank_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_acc_reg   <= '0;
            rsp_lo_reg    <= '0;
            rsp_hi_reg    <= '0;
        end
        else
        begin
            if (rsp.ready && (state_reg != S_OUT))
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        func_reg <= cmd.func;
                        acc_reg  <= bank_get ? 8'(bank_reg) : cmd.acc_in;
                        lo_reg   <= addr_get ? addr_wide[7:0] : cmd.lo_in;
                        hi_reg   <= addr_get ? addr_wide[15:8] : cmd.hi_in;
                        unique case (cmd.func)
                            FUNC_ADDR, FUNC_BANK:
                            begin
                                state_reg <= cmd.write ? S_REM : S_OUT;
                            end
                            FUNC_BYTE, FUNC_NEXT, FUNC_WORD:
                            begin
                                state_reg <= cmd.write ? S_WR_LO : S_RD_LO;
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_REM:
                begin
                    if (rem_done)
                    begin
                        if (func_reg == FUNC_ADDR)
                        begin
                            addr_reg <= rem_result[AW-1:0];
                        end
                        else
                        begin
                            bank_reg <= rem_result[BW-1:0];
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_WR_LO:
                begin
                    if (inc)
                    begin
                        addr_reg <= addr_adv;
                        bank_reg <= bank_adv;
                    end
                    state_reg <= word ? S_WR_HI : S_OUT;
                end
                S_WR_HI:
                begin
                    addr_reg  <= addr_adv;
                    bank_reg  <= bank_adv;
                    state_reg <= S_OUT;
                end
                S_RD_LO:
                begin
                    if (inc)
                    begin
                        addr_reg <= addr_adv;
                        bank_reg <= bank_adv;
                    end
                    state_reg <= word ? S_RD_HI : S_RD_TAIL;
                end
                S_RD_HI:
                begin
                    lo_reg    <= mem_rdata;
                    addr_reg  <= addr_adv;
                    bank_reg  <= bank_adv;
                    state_reg <= S_RD_TAIL;
                end
                S_RD_TAIL:
                begin
                    if (word)
                    begin
                        hi_reg <= mem_rdata;
                    end
                    else
                    begin
                        acc_reg <= mem_rdata;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // Hold until the output register is free
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_acc_reg   <= acc_reg;
                        rsp_lo_reg    <= lo_reg;
                        rsp_hi_reg    <= hi_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.acc_out = rsp_acc_reg;
    assign rsp.lo_out  = rsp_lo_reg;
    assign rsp.hi_out  = rsp_hi_reg;

    // Checks
    `BEMP_ASSERT_ALWAYS(a_addr_in_range, addr_reg <= ADDR_MAX)
    `BEMP_ASSERT_ALWAYS(a_bank_in_range, bank_reg <= BANK_MAX)
    `BEMP_ASSERT(a_rem_done_in_rem, rem_done |-> (state_reg == S_REM))
    `BEMP_ASSERT(a_rsp_from_out, $rose(rsp_valid_reg) |-> $past(state_reg == S_OUT))

endmodule

/* tb/sv/banked_expansion_memory_port_unit_tb.sv */
`timescale 1ns / 100ps

module banked_expansion_memory_port_unit_tb;

    import bemp_pkg::*;

    // Codes with no command behind them; the block passes the registers through
    localparam logic [2:0] FUNC_SPARE5 = 3'd5;
    localparam logic [2:0] FUNC_SPARE6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE7 = 3'd7;

    // Write flag meaning
    localparam logic CMD_SET = 1'b1;
    localparam logic CMD_GET = 1'b0;

    localparam int RANDOM_ITEMS = 1200;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PRINT_CAP    = 40;

    typedef struct packed {
        logic [2:0] func;
        logic       write;
        logic [7:0] acc;
        logic [7:0] lo;
        logic [7:0] hi;
    } port_cmd_t;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] lo;
        logic [7:0] hi;
    } port_rsp_t;

    typedef struct packed {
        port_cmd_t cmd;
        logic      known;
        port_rsp_t want;
    } port_row_t;

    logic clk;
    logic rst_n;

    bemp_cmd_if cmd_ch ();
    bemp_rsp_if rsp_ch ();

    banked_expansion_memory_port_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Shadow of the pointer, bank and every byte written since reset
    logic [15:0] ptr_addr;
    logic [3:0]  ptr_bank;
    logic [7:0]  shadow_mem [int];

    port_rsp_t pending_results [$];
    int        error_count;
    int        items_sent;
    int        cycle_count;
    int        tx_idle_pct;
    int        rx_idle_pct;

    // Directed commands; results typed in only where they are obvious
    port_row_t directed_rows [26] = '{
        // gets right after reset
        '{'{FUNC_ADDR, CMD_GET, 8'hA5, 8'h12, 8'h34}, 1'b1, '{8'hA5, 8'h00, 8'h00}},
        '{'{FUNC_BANK, CMD_GET, 8'h3C, 8'h81, 8'h7E}, 1'b1, '{8'h00, 8'h81, 8'h7E}},
        // unused codes pass everything through
        '{'{FUNC_SPARE5, CMD_SET, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{8'hFF, 8'hFF, 8'hFF}},
        '{'{FUNC_SPARE6, CMD_GET, 8'h00, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'h00, 8'h00}},
        '{'{FUNC_SPARE7, CMD_SET, 8'h80, 8'h01, 8'hFE}, 1'b1, '{8'h80, 8'h01, 8'hFE}},
        // top of the last bank; bank set keeps only the low nibble
        '{'{FUNC_ADDR, CMD_SET, 8'h00, 8'hFF, 8'hFF}, 1'b1, '{8'h00, 8'hFF, 8'hFF}},
        '{'{FUNC_BANK, CMD_SET, 8'hFF, 8'hFF, 8'h00}, 1'b1, '{8'hFF, 8'hFF, 8'h00}},
        '{'{FUNC_BANK, CMD_GET, 8'h00, 8'h00, 8'h00}, 1'b1, '{8'h0F, 8'h00, 8'h00}},
        '{'{FUNC_ADDR, CMD_GET, 8'h00, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'hFF, 8'hFF}},
        // byte access without increment
        '{'{FUNC_BYTE, CMD_SET, 8'h00, 8'h5A, 8'hFF}, 1'b1, '{8'h00, 8'h5A, 8'hFF}},
        '{'{FUNC_BYTE, CMD_GET, 8'hFF, 8'h00, 8'h00}, 1'b0, '{8'h00, 8'h00, 8'h00}},
        // increment past the last address of the last bank wraps both
        '{'{FUNC_NEXT, CMD_SET, 8'h55, 8'hC3, 8'hAA}, 1'b0, '{8'h00, 8'h00, 8'h00}},
        '{'{FUNC_BANK, CMD_GET, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '{8'h00, 8'h00, 8'h00}},
        '{'{FUNC_ADDR, CMD_GET, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '{8'h00, 8'h00, 8'h00}},
        // word write across a bank boundary
        '{'{FUNC_BANK, CMD_SET, 8'h00, 8'hF7, 8'h00}, 1'b0, '{8'h00, 8'h00, 8'h00}},
        '{'{FUNC_ADDR, CMD_SET, 8'h00, 8'hFF, 8'hFF}, 1'b0, '{8'h00, 8'h00, 8'h00}},
        '{'{FUNC_WORD, CMD_SET, 8'h7F, 8'h11, 8'h22}, 1'b0, '{8'h00, 8'h00, 8'h00}},
        '{'{FUNC_BANK, CMD_GET, 8'h00, 8'h00, 8'h00}, 1'b0, '{8'h00, 8'h00, 8'h00}},
        '{'{FUNC_ADDR, CMD_GET, 8'h00, 8'h00, 8'h00}, 1'b0, '{8'h00, 8'h00, 8'h00}},
        // read the same word back
        '{'{FUNC_BANK, CMD_SET, 8'h00, 8'h07, 8'h00}, 1'b0, '{8'h00, 8'h00, 8'h00}},
        '{'{FUNC_ADDR, CMD_SET, 8'h00, 8'hFF, 8'hFF}, 1'b0, '{8'h00, 8'h00, 8'h00}},
        '{'{FUNC_WORD, CMD_GET, 8'h99, 8'h00, 8'hFF}, 1'b0, '{8'h00, 8'h00, 8'h00}},
        // read with increment across the top of the last bank
        '{'{FUNC_BANK, CMD_SET, 8'h00, 8'h0F, 8'h00}, 1'b0, '{8'h00, 8'h00, 8'h00}},
        '{'{FUNC_ADDR, CMD_SET, 8'h00, 8'hFF, 8'hFF}, 1'b0, '{8'h00, 8'h00, 8'h00}},
        '{'{FUNC_NEXT, CMD_GET, 8'h01, 8'hFE, 8'h80}, 1'b0, '{8'h00, 8'h00, 8'h00}},
        // bank value above the count folds to zero
        '{'{FUNC_BANK, CMD_SET, 8'h00, 8'h10, 8'h00}, 1'b0, '{8'h00, 8'h00, 8'h00}}
    };

    // Read or write one byte at the pointer, then optionally step the pointer;
    // stepping past the top of a bank carries into the bank number
    function automatic logic [7:0] access_byte(logic wr, logic [7:0] data, logic inc);
        int         loc;
        logic [7:0] b;
        loc = int'({ptr_bank, ptr_addr});
        b   = 8'h00;
        if (wr)
            shadow_mem[loc] = data;
        else if (shadow_mem.exists(loc))
            b = shadow_mem[loc];
        if (inc)
            {ptr_bank, ptr_addr} = {ptr_bank, ptr_addr} + 20'd1;
        return b;
    endfunction

    // Work out the result of one command and update the shadow state
    function automatic port_rsp_t predict_port_result(port_cmd_t c);
        port_rsp_t r;
        r = '{c.acc, c.lo, c.hi};
        case (c.func)
            FUNC_ADDR:
                if (c.write)
                    ptr_addr = {c.hi, c.lo};
                else
                begin
                    r.lo = ptr_addr[7:0];
                    r.hi = ptr_addr[15:8];
                end
            FUNC_BANK:
                if (c.write)
                    ptr_bank = c.lo[3:0];
                else
                    r.acc = {4'h0, ptr_bank};
            FUNC_BYTE, FUNC_NEXT:
                if (c.write)
                    void'(access_byte(1'b1, c.lo, c.func == FUNC_NEXT));
                else
                    r.acc = access_byte(1'b0, 8'h00, c.func == FUNC_NEXT);
            FUNC_WORD:
                if (c.write)
                begin
                    void'(access_byte(1'b1, c.lo, 1'b1));
                    void'(access_byte(1'b1, c.hi, 1'b1));
                end
                else
                begin
                    r.lo = access_byte(1'b0, 8'h00, 1'b1);
                    r.hi = access_byte(1'b0, 8'h00, 1'b1);
                end
            default: ;
        endcase
        return r;
    endfunction

    // A store read is allowed only where every byte it touches was written
    function automatic bit can_read(logic [2:0] f);
        logic [19:0] loc;
        logic [19:0] nxt;
        loc = {ptr_bank, ptr_addr};
        nxt = loc + 20'd1;
        if (f == FUNC_WORD)
            return shadow_mem.exists(int'(loc)) && shadow_mem.exists(int'(nxt));
        return shadow_mem.exists(int'(loc));
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Hold the command until it transfers, then queue its expected result.
    // valid is left high on return so a back-to-back command needs no toggle.
    task automatic send_cmd(port_cmd_t c, logic known, port_rsp_t want);
        port_rsp_t pred;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.func   <= c.func;
        cmd_ch.write  <= c.write;
        cmd_ch.acc_in <= c.acc;
        cmd_ch.lo_in  <= c.lo;
        cmd_ch.hi_in  <= c.hi;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        pred = predict_port_result(c);
        pending_results.push_back(known ? want : pred);
        if (c.func <= FUNC_WORD)
            items_sent++;
    endtask

    task automatic issue_cmd(logic [2:0] f, logic wr, logic [7:0] lo, logic [7:0] hi);
        port_cmd_t c;
        c = '{f, wr, 8'($urandom_range(0, 255)), lo, hi};
        send_cmd(c, 1'b0, '0);
    endtask

    // Position the pointer, fill a run of bytes, rewind and read it back
    task automatic run_block_pass();
        logic [7:0]  bank_sel;
        logic [15:0] base;
        logic [2:0]  f;
        int          n_wr;
        bank_sel = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
            base = 16'hFFF0 + 16'($urandom_range(0, 15));
        else
            base = 16'($urandom_range(0, 65535));
        issue_cmd(FUNC_BANK, CMD_SET, bank_sel, 8'($urandom_range(0, 255)));
        issue_cmd(FUNC_ADDR, CMD_SET, base[7:0], base[15:8]);
        n_wr = $urandom_range(1, 8);
        for (int i = 0; i < n_wr; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: f = FUNC_NEXT;
                4, 5, 6:    f = FUNC_WORD;
                7:          f = FUNC_BYTE;
                8:          f = $urandom_range(0, 1) ? FUNC_ADDR : FUNC_BANK;
                default:    f = 3'($urandom_range(5, 7));
            endcase
            // gets in the middle must not move the pointer
            issue_cmd(f, (f == FUNC_ADDR || f == FUNC_BANK) ? CMD_GET : CMD_SET,
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        issue_cmd(FUNC_BANK, CMD_SET, {4'($urandom_range(0, 15)), bank_sel[3:0]},
                  8'($urandom_range(0, 255)));
        issue_cmd(FUNC_ADDR, CMD_SET, base[7:0], base[15:8]);
        for (int i = 0; i < n_wr + 2; i++)
        begin
            case ($urandom_range(0, 3))
                0:       f = FUNC_BYTE;
                1:       f = FUNC_WORD;
                default: f = FUNC_NEXT;
            endcase
            if (!can_read(f))
                break;
            issue_cmd(f, CMD_GET, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
    endtask

    // Single random command at wherever the pointer happens to be
    task automatic issue_noise();
        logic [2:0] f;
        logic       wr;
        f  = 3'($urandom_range(0, 7));
        wr = 1'($urandom_range(0, 1));
        if (wr == CMD_GET && f >= FUNC_BYTE && f <= FUNC_WORD && !can_read(f))
            wr = CMD_SET;
        issue_cmd(f, wr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result side: stall at the current rate
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        port_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result %h %h %h",
                                rsp_ch.acc_out, rsp_ch.lo_out, rsp_ch.hi_out));
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.acc_out !== want.acc)
                    report_mismatch($sformatf("acc_out %h, expected %h",
                                    rsp_ch.acc_out, want.acc));
                if (rsp_ch.lo_out !== want.lo)
                    report_mismatch($sformatf("lo_out %h, expected %h",
                                    rsp_ch.lo_out, want.lo));
                if (rsp_ch.hi_out !== want.hi)
                    report_mismatch($sformatf("hi_out %h, expected %h",
                                    rsp_ch.hi_out, want.hi));
            end
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Stimulus
    initial
    begin
        error_count = 0;
        items_sent  = 0;
        ptr_addr    = 16'h0000;
        ptr_bank    = 4'h0;
        tx_idle_pct = 13;
        rx_idle_pct = 62;
        rst_n         <= 1'b0;
        cmd_ch.valid  <= 1'b0;
        cmd_ch.func   <= FUNC_ADDR;
        cmd_ch.write  <= CMD_GET;
        cmd_ch.acc_in <= 8'h00;
        cmd_ch.lo_in  <= 8'h00;
        cmd_ch.hi_in  <= 8'h00;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_cmd(directed_rows[i].cmd, directed_rows[i].known, directed_rows[i].want);

        // Random part in three idling phases
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else if (items_sent >= RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 62;
                rx_idle_pct = 13;
            end
            if ($urandom_range(0, 99) < 20)
                issue_noise();
            else
                run_block_pass();
        end
        cmd_ch.valid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/bemp_pkg.sv
hw/rtl/bemp_cmd_if.sv
hw/rtl/bemp_rsp_if.sv
hw/rtl/bemp_rem_unit.sv
hw/rtl/bemp_store.sv
hw/rtl/banked_expansion_memory_port_unit.sv
tb/sv/banked_expansion_memory_port_unit_tb.sv
